FILE: hw/rtl/curling_rotten_word_test_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef CURLING_ROTTEN_WORD_TEST_DEFINES_SVH
`define CURLING_ROTTEN_WORD_TEST_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define CRWT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("check failed: name");

// Property that must never hold outside reset.
`define CRWT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition: name");

`endif

FILE: hw/rtl/crwt_pkg.sv
package crwt_pkg;

  localparam int unsigned SymW = 8;
  localparam int unsigned StepW = 8;
  localparam int unsigned WordW = 48;
  localparam int unsigned LenCfgW = 6;
  localparam int unsigned TauW = 7;

  localparam logic [SymW-1:0] SymTwo = 8'd2;
  localparam logic [SymW-1:0] SymThree = 8'd3;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic            clr;
    logic            app;
    logic [SymW-1:0] sym;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_SETTLE,
    ST_DONE
  } state_e;

endpackage

FILE: hw/rtl/crwt_cell.sv
module crwt_cell
  import crwt_pkg::*;
#(
  parameter int unsigned P  = 1,
  parameter int unsigned KW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [SymW-1:0] sym_i,
  input  logic            vld_i,
  input  logic [KW-1:0]   m_i,
  output logic [SymW-1:0] sym_o,
  output logic            vld_o,
  output logic [KW-1:0]   m_o
);

  localparam int unsigned PW = (P > 1) ? $clog2(P) : 1;

  // This cell holds the symbol P places back from the end, and tracks how
  // many whole periods of length P repeat at the end of the sequence.
  logic [SymW-1:0] sym_q, sym_d;
  logic            vld_q, vld_d;
  logic [PW-1:0]   ph_q, ph_d;
  logic [KW-1:0]   k_q, k_d;
  logic [KW-1:0]   m_q, m_d;
  logic            match;

  always_comb begin
    sym_d = sym_q;
    vld_d = vld_q;
    ph_d  = ph_q;
    k_d   = k_q;
    match = vld_q && (ctrl_i.sym == sym_q);
    if (ctrl_i.clr) begin
      vld_d = 1'b0;
      ph_d  = '0;
      k_d   = KW'(1);
    end else if (ctrl_i.app) begin
      sym_d = sym_i;
      vld_d = vld_i;
      if (match) begin
        if (ph_q == PW'(P - 1)) begin
          ph_d = '0;
          k_d  = k_q + KW'(1);
        end else begin
          ph_d = ph_q + PW'(1);
        end
      end else begin
        ph_d = '0;
        k_d  = KW'(1);
      end
    end
    m_d = (k_q > m_i) ? k_q : m_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      ph_q  <= '0;
      k_q   <= KW'(1);
      m_q   <= KW'(1);
    end else begin
      vld_q <= vld_d;
      ph_q  <= ph_d;
      k_q   <= k_d;
      m_q   <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign sym_o = sym_q;
  assign vld_o = vld_q;
  assign m_o   = m_q;

endmodule

FILE: hw/rtl/curling_rotten_word_test.sv
// Each item takes three runs (plain, 2 prepended, 3 prepended). Each run has a
// clear state, a load state that appends the start symbols, then a settle pass
// through the cell chain for each of up to STEP_LIMIT + 1 curling checks.
// One item at a time; a new item is taken once the previous result is out.
// Reset (rst_ni low, asynchronous) clears control state and sets
// word_length to 8; the symbol cells need no clearing pass.
`include "curling_rotten_word_test_defines.svh"
module curling_rotten_word_test
  import crwt_pkg::*;
#(
  parameter int unsigned MAX_WORD    = 48,
  parameter int unsigned STEP_LIMIT  = 120,
  parameter int unsigned STORE_DEPTH = 172
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LenCfgW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WordW-1:0]   word_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TauW-1:0]    steps_plain_o,
  output logic [TauW-1:0]    steps_two_prefix_o,
  output logic [TauW-1:0]    steps_three_prefix_o,
  output logic               is_rotten_o,
  output logic               is_doubly_rotten_o,
  output logic               bound_exceeded_o
);

  localparam int unsigned NC = STORE_DEPTH / 2;
  localparam int unsigned LW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW = $clog2(NC + 1);

  state_e state_q, state_d;
  logic [LenCfgW-1:0] wl_q;
  logic [WordW-1:0]   word_q, word_d;
  logic [LenCfgW-1:0] rem_q, rem_d;
  logic               pre_q, pre_d;
  logic [1:0]         run_q, run_d;
  logic [LW-1:0]      len_q, len_d;
  logic [StepW-1:0]   t_q, t_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               over_q, over_d;
  logic [StepW-1:0]   tau0_q, tau0_d, tau1_q, tau1_d;
  logic               out_valid_q, out_valid_d;
  logic [TauW-1:0]    o_plain_q, o_two_q, o_three_q;
  logic               o_rot_q, o_drot_q, o_over_q;
  logic               out_load;
  logic [LenCfgW-1:0] n_sat;
  logic [9:0]         c_ext;
  logic               ra, rb;
  cell_ctrl_t         ctrl;

  logic [SymW-1:0] sym_w [0:NC];
  logic            vld_w [0:NC];
  logic [LW-1:0]   m_w   [0:NC];

  assign sym_w[0] = ctrl.sym;
  assign vld_w[0] = 1'b1;
  assign m_w[0]   = LW'(1);

  for (genvar g = 1; g <= NC; g++) begin : g_cell
    crwt_cell #(.P(g), .KW(LW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sym_i  (sym_w[g-1]),
      .vld_i  (vld_w[g-1]),
      .m_i    (m_w[g-1]),
      .sym_o  (sym_w[g]),
      .vld_o  (vld_w[g]),
      .m_o    (m_w[g])
    );
  end

  assign n_sat = (wl_q > LenCfgW'(MAX_WORD)) ? LenCfgW'(MAX_WORD) : wl_q;
  assign c_ext = 10'(m_w[NC]);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    rem_d   = rem_q;
    pre_d   = pre_q;
    run_d   = run_q;
    len_d   = len_q;
    t_d     = t_q;
    cnt_d   = cnt_q;
    over_d  = over_q;
    tau0_d  = tau0_q;
    tau1_d  = tau1_q;
    out_load = 1'b0;
    ctrl.clr = 1'b0;
    ctrl.app = 1'b0;
    ctrl.sym = SymTwo;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          word_d  = word_bits_i;
          run_d   = 2'd0;
          over_d  = 1'b0;
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        ctrl.clr = 1'b1;
        rem_d    = n_sat;
        pre_d    = (run_q != 2'd0);
        len_d    = '0;
        t_d      = '0;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        if (pre_q) begin
          ctrl.app = 1'b1;
          ctrl.sym = (run_q == 2'd1) ? SymTwo : SymThree;
          pre_d    = 1'b0;
          len_d    = len_q + LW'(1);
        end else if (rem_q != '0) begin
          ctrl.app = 1'b1;
          // Bit order walks the word from its low end, one symbol per cycle.
          ctrl.sym = word_q[(n_sat - rem_q) +: 1] ? SymThree : SymTwo;
          rem_d    = rem_q - LenCfgW'(1);
          len_d    = len_q + LW'(1);
        end else begin
          cnt_d   = '0;
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (cnt_q != CW'(NC)) begin
          cnt_d = cnt_q + CW'(1);
        end else begin
          cnt_d = '0;
          if (c_ext == 10'd1 || t_q >= StepW'(STEP_LIMIT) ||
              len_q >= LW'(STORE_DEPTH)) begin
            if (c_ext != 10'd1) begin
              over_d = 1'b1;
              t_d    = StepW'(STEP_LIMIT);
            end
            if (run_q == 2'd0) tau0_d = (c_ext != 10'd1) ? StepW'(STEP_LIMIT) : t_q;
            if (run_q == 2'd1) tau1_d = (c_ext != 10'd1) ? StepW'(STEP_LIMIT) : t_q;
            if (run_q == 2'd2) begin
              state_d = ST_DONE;
            end else begin
              run_d   = run_q + 2'd1;
              state_d = ST_CLEAR;
            end
          end else begin
            ctrl.app = 1'b1;
            ctrl.sym = (c_ext > 10'd255) ? 8'hFF : c_ext[7:0];
            len_d    = len_q + LW'(1);
            t_d      = t_q + StepW'(1);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ra = !over_q && (tau1_q < tau0_q);
  assign rb = !over_q && (t_q < tau0_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wl_q        <= LenCfgW'(8);
      out_valid_q <= 1'b0;
      run_q       <= '0;
      pre_q       <= 1'b0;
      rem_q       <= '0;
      len_q       <= '0;
      t_q         <= '0;
      cnt_q       <= '0;
      over_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      run_q       <= run_d;
      pre_q       <= pre_d;
      rem_q       <= rem_d;
      len_q       <= len_d;
      t_q         <= t_d;
      cnt_q       <= cnt_d;
      over_q      <= over_d;
      if (cfg_we_i) wl_q <= cfg_wdata_i;
    end
  end

  // In the done state t_q holds the tau of the run with 3 prepended.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    tau0_q <= tau0_d;
    tau1_q <= tau1_d;
    if (out_load) begin
      o_plain_q <= tau0_q[TauW-1:0];
      o_two_q   <= tau1_q[TauW-1:0];
      o_three_q <= t_q[TauW-1:0];
      o_rot_q   <= ra || rb;
      o_drot_q  <= ra && rb;
      o_over_q  <= over_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign steps_plain_o        = o_plain_q;
  assign steps_two_prefix_o   = o_two_q;
  assign steps_three_prefix_o = o_three_q;
  assign is_rotten_o          = o_rot_q;
  assign is_doubly_rotten_o   = o_drot_q;
  assign bound_exceeded_o     = o_over_q;

  `CRWT_ASSERT(a_hold_result, out_valid_o && out_stall_i |=> out_valid_o)
  `CRWT_ASSERT(a_busy_after_transfer, in_valid_i && !in_stall_o |=> in_stall_o)
  `CRWT_NEVER(a_flags_under_bound, out_valid_o && bound_exceeded_o && is_rotten_o)
  `CRWT_NEVER(a_doubly_implies_rotten, out_valid_o && is_doubly_rotten_o && !is_rotten_o)

endmodule
